[src/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Longest search pattern the window can hold
  localparam int PATTERN_BYTES = 8;
  // Longest replacement
  localparam int REPLACE_MAX   = 8;
  // Most result beats one input beat can cause
  localparam int BATCH_MAX     = (PATTERN_BYTES > REPLACE_MAX) ? PATTERN_BYTES : REPLACE_MAX;

  localparam int FILL_W = $clog2(PATTERN_BYTES + 1);
  localparam int CNT_W  = $clog2(BATCH_MAX + 1);
  localparam int LEN_W  = 4;
  localparam int PAT_W  = 64;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    REG_SEARCH_PATTERN  = 2'd0,
    REG_SEARCH_LENGTH   = 2'd1,
    REG_REPLACE_PATTERN = 2'd2,
    REG_REPLACE_LENGTH  = 2'd3
  } sfr_reg_idx_t;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } sfr_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       out_end;
  } sfr_out_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [PAT_W-1:0]  search_pattern;
    logic [FILL_W-1:0] search_len;    // saturated to PATTERN_BYTES
    logic [PAT_W-1:0]  replace_pattern;
    logic [CNT_W-1:0]  replace_len;   // saturated to REPLACE_MAX
    logic              win_clear;     // search length was just written
  } sfr_cfg_t;

  // All result beats caused by one input beat
  typedef struct packed {
    logic [BATCH_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      last;  // stream ends with this batch
    logic                      bare;  // single end marker without data
  } sfr_batch_t;

endpackage

[src/sfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// APB register file for the search and replacement settings.
// ----------------------------------------------------------------------------
module sfr_cfg_regs
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sfr_cfg_t          cfg
);

  logic [PAT_W-1:0] spat_r, spat_nxt;
  logic [LEN_W-1:0] slen_r, slen_nxt;
  logic [PAT_W-1:0] rpat_r, rpat_nxt;
  logic [LEN_W-1:0] rlen_r, rlen_nxt;
  logic             wr_en;
  logic             clr;
  sfr_reg_idx_t     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = sfr_reg_idx_t'(paddr[ADDR_W-1:3]);

  // Decode register writes
  always_comb begin
    spat_nxt = spat_r;
    slen_nxt = slen_r;
    rpat_nxt = rpat_r;
    rlen_nxt = rlen_r;
    clr      = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_SEARCH_PATTERN: begin
          spat_nxt = pwdata[PAT_W-1:0];
        end
        REG_SEARCH_LENGTH: begin
          slen_nxt = pwdata[LEN_W-1:0];
          clr      = 1'b1;
        end
        REG_REPLACE_PATTERN: begin
          rpat_nxt = pwdata[PAT_W-1:0];
        end
        REG_REPLACE_LENGTH: begin
          rlen_nxt = pwdata[LEN_W-1:0];
        end
        default: begin
          clr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spat_r <= '0;
      slen_r <= '0;
      rpat_r <= '0;
      rlen_r <= '0;
    end else begin
      spat_r <= spat_nxt;
      slen_r <= slen_nxt;
      rpat_r <= rpat_nxt;
      rlen_r <= rlen_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_SEARCH_PATTERN:  prdata = DATA_W'(spat_r);
      REG_SEARCH_LENGTH:   prdata = DATA_W'(slen_r);
      REG_REPLACE_PATTERN: prdata = DATA_W'(rpat_r);
      REG_REPLACE_LENGTH:  prdata = DATA_W'(rlen_r);
      default:             prdata = '0;
    endcase
  end

  // Saturate lengths for the datapath
  always_comb begin
    cfg.search_pattern  = spat_r;
    cfg.replace_pattern = rpat_r;
    cfg.win_clear       = clr;
    if (slen_r > LEN_W'(PATTERN_BYTES)) begin
      cfg.search_len = FILL_W'(PATTERN_BYTES);
    end else begin
      cfg.search_len = FILL_W'(slen_r);
    end
    if (rlen_r > LEN_W'(REPLACE_MAX)) begin
      cfg.replace_len = CNT_W'(REPLACE_MAX);
    end else begin
      cfg.replace_len = CNT_W'(rlen_r);
    end
  end

endmodule

[src/sfr_window.sv]
// ----------------------------------------------------------------------------
// sfr_window
// Sliding window of pending bytes; matches it against the pattern and forms
// the batch of result bytes for each accepted input beat.
// ----------------------------------------------------------------------------
module sfr_window
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sfr_cfg_t   cfg,
  input  logic       accept,
  input  sfr_in_t    in_item,
  output sfr_batch_t batch
);

  logic [PATTERN_BYTES-1:0][7:0] win_r, win_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;

  logic [PATTERN_BYTES-1:0][7:0] wp;
  logic [FILL_W-1:0]             fill_eff;
  logic [FILL_W-1:0]             fill_inc;
  logic                          full;
  logic                          match;
  logic [FILL_W-1:0]             len;

  assign len = cfg.search_len;

  // Place the new byte behind the pending ones
  always_comb begin
    if (len != '0 && fill_r >= len) begin
      fill_eff = len - FILL_W'(1);
    end else begin
      fill_eff = fill_r;
    end
    fill_inc = fill_eff + FILL_W'(1);
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      wp[i] = (FILL_W'(i) == fill_eff) ? in_item.in_byte : win_r[i];
    end
    full  = (fill_inc == len);
    match = 1'b1;
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      if (FILL_W'(i) < len && wp[i] != cfg.search_pattern[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  // Form the result batch and the next window
  always_comb begin
    batch.bytes = '0;
    batch.cnt   = '0;
    batch.last  = in_item.in_end;
    batch.bare  = 1'b0;
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    if (len == '0) begin
      // pass through
      batch.bytes[0] = in_item.in_byte;
      batch.cnt      = CNT_W'(1);
    end else if (full && match) begin
      for (int i = 0; i < REPLACE_MAX; i++) begin
        batch.bytes[i] = cfg.replace_pattern[8*i +: 8];
      end
      batch.cnt = cfg.replace_len;
      fill_nxt  = '0;
    end else begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        batch.bytes[i] = wp[i];
      end
      if (full) begin
        // emit the oldest byte, flush the rest on the end beat
        batch.cnt = in_item.in_end ? CNT_W'(len) : CNT_W'(1);
        for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
          win_nxt[i] = wp[i+1];
        end
        fill_nxt = in_item.in_end ? '0 : len - FILL_W'(1);
      end else begin
        batch.cnt = in_item.in_end ? CNT_W'(fill_inc) : '0;
        win_nxt   = wp;
        fill_nxt  = in_item.in_end ? '0 : fill_inc;
      end
    end
    // bare end marker when nothing is left to send
    if (in_item.in_end && batch.cnt == '0) begin
      batch.bytes = '0;
      batch.cnt   = CNT_W'(1);
      batch.bare  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg.win_clear) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

[src/sfr_out_queue.sv]
// ----------------------------------------------------------------------------
// sfr_out_queue
// Result register: holds one batch and sends it out one beat per cycle unless out_stall is high.
// ----------------------------------------------------------------------------
module sfr_out_queue
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sfr_batch_t batch,
  input  logic       load_req,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output sfr_out_t   out_data
);

  logic [BATCH_MAX-1:0][7:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      last_r, last_nxt;
  logic                      bare_r, bare_nxt;
  logic                      take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && !out_stall;
  assign can_load  = (cnt_r == '0) || (cnt_r == CNT_W'(1) && !out_stall);

  assign out_data.out_byte       = bytes_r[0];
  assign out_data.out_byte_valid = !bare_r;
  assign out_data.out_end        = last_r && (cnt_r == CNT_W'(1));

  // Load a new batch or advance the current one
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    bare_nxt  = bare_r;
    if (take) begin
      for (int i = 0; i < BATCH_MAX - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (load_req && batch.cnt != '0) begin
      bytes_nxt = batch.bytes;
      cnt_nxt   = batch.cnt;
      last_nxt  = batch.last;
      bare_nxt  = batch.bare;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    last_r  <= last_nxt;
    bare_r  <= bare_nxt;
  end

endmodule

[src/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace on a byte stream.
// ----------------------------------------------------------------------------
// Each input beat carries one byte; every leftmost, non-overlapping match of
// the search pattern (up to 8 bytes) is replaced by the replacement (0 to 8
// bytes), and in_end flushes the pending window. An input beat's result bytes
// leave from the result register one per cycle while out_stall is low,
// starting the cycle after the beat is taken, so a stream with one result
// per input runs at one byte per clock while out_stall is low. A beat that
// causes n results keeps in_stall high while more than one of them is left
// to send, and also while out_stall holds its last byte; the next beat is
// taken in the cycle the last of the n bytes leaves. Bytes that only fill
// the window produce no result beat. Write configuration only while no beat
// is in flight; writing the search length drops any pending window bytes.
// ----------------------------------------------------------------------------
module stream_find_replace
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input stream
  input  logic              in_valid,
  output logic              in_stall,
  input  sfr_in_t           in_data,
  // result stream
  output logic              out_valid,
  input  logic              out_stall,
  output sfr_out_t          out_data
);

  sfr_cfg_t   cfg;
  sfr_batch_t batch;
  logic       can_load;
  logic       accept;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_window u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .in_item (in_data),
    .batch   (batch)
  );

  sfr_out_queue u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .load_req  (accept),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
